// ===== rtl/wgas_pkg.sv =====
// Shared types, constants and state codes for the weighted graph adjacency store.
`default_nettype none

package wgas_pkg;

    localparam int NAME_W        = 8;
    localparam int WEIGHT_W      = 16;
    localparam int STATUS_W      = 3;
    localparam int IDX_OUT_W     = 4;
    localparam int MAX_NODES_DEF = 16;

    localparam logic [WEIGHT_W-1:0] NO_EDGE = {WEIGHT_W{1'b1}};

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_REPLACED = 3'd5;

    localparam logic FUNC_NODE = 1'b0;
    localparam logic FUNC_EDGE = 1'b1;

    typedef struct packed {
        logic                       func;
        logic [NAME_W-1:0]          first_name;
        logic [NAME_W-1:0]          second_name;
        logic signed [WEIGHT_W-1:0] edge_weight;
    } wgas_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_OUT_W-1:0] origin_index;
        logic [IDX_OUT_W-1:0] dest_index;
    } wgas_result_t;

    typedef struct packed {
        logic              search;
        logic              load;
        logic [NAME_W-1:0] key_a;
        logic [NAME_W-1:0] key_b;
        logic [NAME_W-1:0] new_name;
    } wgas_cell_ctrl_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_WRITE2
    } wgas_state_t;

endpackage

`default_nettype wire

// ===== rtl/wgas_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module wgas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/wgas_cell.sv =====
// One name slot of the node table: holds a name, compares it and passes its fill bit on.
`default_nettype none

module wgas_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wgas_pkg::wgas_cell_ctrl_t ctrl,
    input  logic                     prev_valid,
    output logic                     valid,
    output logic                     match_a,
    output logic                     match_b
);

    import wgas_pkg::*;

    logic [NAME_W-1:0] name_reg;
    logic              valid_reg;
    logic              match_a_reg;
    logic              match_b_reg;
    logic              take;

    // Only the first empty slot, whose left neighbour is filled, takes the new name.
    assign take = ctrl.load && prev_valid && !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            match_a_reg <= 1'b0;
            match_b_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            if (ctrl.search)
            begin
                match_a_reg <= valid_reg && (name_reg == ctrl.key_a);
                match_b_reg <= valid_reg && (name_reg == ctrl.key_b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            name_reg <= ctrl.new_name;
        end
    end

    assign valid   = valid_reg;
    assign match_a = match_a_reg;
    assign match_b = match_b_reg;

endmodule

`default_nettype wire

// ===== rtl/weighted_graph_adjacency_store.sv =====
// Top level of the weighted graph adjacency store: name cell row, weight RAM and sequencer.
`default_nettype none

// Usage
// An item is accepted at a rising edge where start is high and busy is low. Each item
// gives exactly one result, shown on result for one cycle while done is high; the
// receiver cannot hold it off, so it must take it in that cycle.
// A node insert, or an edge insert that is refused, goes from acceptance to result by
// searching the name cells and then deciding and appending. An edge insert that is
// carried out goes through search, decide and issue the weight RAM read, check the old
// entry and write the first entry, write the symmetric entry. busy stays high from
// acceptance until the result is shown, so no new item is taken while one is in
// progress; the read-then-two-writes sequence through the weight RAM's one write port
// is what makes a carried-out edge insert the longer case.
// After reset the weight matrix is swept to minus one (no edge), one entry a cycle;
// busy is high for that whole sweep.
// The name table is a row of cells filled from slot zero upwards; a cell's fill bit
// feeds its right-hand neighbour, so the row itself acts as the node count.

module weighted_graph_adjacency_store #(
    parameter int MAX_NODES = wgas_pkg::MAX_NODES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  wgas_pkg::wgas_item_t     item,
    output logic                     done,
    output wgas_pkg::wgas_result_t   result
);

    import wgas_pkg::*;

    localparam int IW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Sequencer and item registers.
    wgas_state_t   state_reg, state_next;
    wgas_item_t    item_reg;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] od_reg, od_next;
    logic [AW-1:0] do_reg, do_next;
    logic [IW-1:0] o_idx_reg, o_idx_next;
    logic [IW-1:0] d_idx_reg, d_idx_next;
    wgas_result_t  result_reg, result_next;
    logic          done_reg, done_next;
    logic          accept;

    // Cell row.
    wgas_cell_ctrl_t        cell_ctrl;
    logic                   cell_load;
    logic [MAX_NODES-1:0]   valid_vec;
    logic [MAX_NODES-1:0]   prev_valid_vec;
    logic [MAX_NODES-1:0]   match_a_vec;
    logic [MAX_NODES-1:0]   match_b_vec;
    logic [MAX_NODES-1:0]   valid_inc;

    // Search results decoded from the cell row.
    logic [IW-1:0] o_idx;
    logic [IW-1:0] d_idx;
    logic          found_a;
    logic          found_b;
    logic          table_full;
    logic          table_empty;
    logic [AW-1:0] od_addr;
    logic [AW-1:0] do_addr;

    // Weight RAM ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WEIGHT_W-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WEIGHT_W-1:0] ram_rdata;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // The cells compare the incoming names at the acceptance edge, so the match flags
    // are ready in the first cycle after acceptance.
    always_comb
    begin
        cell_ctrl.search   = accept;
        cell_ctrl.load     = cell_load;
        cell_ctrl.key_a    = item.first_name;
        cell_ctrl.key_b    = item.second_name;
        cell_ctrl.new_name = item_reg.first_name;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NODES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign prev_valid_vec[gi] = 1'b1;
            end
            else
            begin : g_link
                assign prev_valid_vec[gi] = valid_vec[gi-1];
            end

            wgas_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .prev_valid (prev_valid_vec[gi]),
                .valid      (valid_vec[gi]),
                .match_a    (match_a_vec[gi]),
                .match_b    (match_b_vec[gi])
            );
        end
    endgenerate

    // Names are kept unique, so at most one cell matches each key and a plain OR of
    // the slot numbers gives the index.
    always_comb
    begin
        o_idx = '0;
        d_idx = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (match_a_vec[i])
            begin
                o_idx = o_idx | IW'(i);
            end
            if (match_b_vec[i])
            begin
                d_idx = d_idx | IW'(i);
            end
        end
    end

    assign found_a     = |match_a_vec;
    assign found_b     = |match_b_vec;
    assign table_full  = valid_vec[MAX_NODES-1];
    assign table_empty = !valid_vec[0];
    assign od_addr     = AW'(AW'(o_idx) * AW'(MAX_NODES) + AW'(d_idx));
    assign do_addr     = AW'(AW'(d_idx) * AW'(MAX_NODES) + AW'(o_idx));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (item_reg.func == FUNC_EDGE && !table_empty && found_a && found_b)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE2;
            end
            S_WRITE2:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output and datapath control logic.
    always_comb
    begin
        ram_we        = 1'b0;
        ram_waddr     = od_reg;
        ram_wdata     = $unsigned(item_reg.edge_weight);
        ram_raddr     = od_addr;
        cell_load     = 1'b0;
        clr_addr_next = clr_addr_reg;
        od_next       = od_reg;
        do_next       = do_reg;
        o_idx_next    = o_idx_reg;
        d_idx_next    = d_idx_reg;
        result_next   = result_reg;
        done_next     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = NO_EDGE;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            S_IDLE:
            begin
            end
            S_DECIDE:
            begin
                result_next.origin_index = '0;
                result_next.dest_index   = '0;
                if (item_reg.func == FUNC_NODE)
                begin
                    done_next = 1'b1;
                    if (table_full)
                    begin
                        result_next.status = STATUS_FULL;
                    end
                    else if (found_a)
                    begin
                        result_next.status = STATUS_DUP;
                    end
                    else
                    begin
                        cell_load          = 1'b1;
                        result_next.status = STATUS_OK;
                    end
                end
                else if (table_empty)
                begin
                    done_next          = 1'b1;
                    result_next.status = STATUS_EMPTY;
                end
                else if (!found_a || !found_b)
                begin
                    done_next          = 1'b1;
                    result_next.status = STATUS_UNKNOWN;
                end
                else
                begin
                    // The read of the origin-to-destination entry is issued here.
                    od_next    = od_addr;
                    do_next    = do_addr;
                    o_idx_next = o_idx;
                    d_idx_next = d_idx;
                end
            end
            S_READ:
            begin
                ram_we    = 1'b1;
                ram_waddr = od_reg;
                if (ram_rdata != NO_EDGE)
                begin
                    result_next.status = STATUS_REPLACED;
                end
                else
                begin
                    result_next.status = STATUS_OK;
                end
            end
            S_WRITE2:
            begin
                ram_we                   = 1'b1;
                ram_waddr                = do_reg;
                done_next                = 1'b1;
                result_next.origin_index = IDX_OUT_W'(o_idx_reg);
                result_next.dest_index   = IDX_OUT_W'(d_idx_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        od_reg     <= od_next;
        do_reg     <= do_next;
        o_idx_reg  <= o_idx_next;
        d_idx_reg  <= d_idx_next;
        result_reg <= result_next;
    end

    wgas_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done   = done_reg;
    assign result = result_reg;

    // The cell row must always be filled from slot zero upwards without gaps.
    assign valid_inc = valid_vec + MAX_NODES'(1);

    a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & valid_inc) == '0)
        else $error("name cells are not filled contiguously");

    // Stored names are unique, so a search never hits more than one cell.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_a_vec) && $onehot0(match_b_vec))
        else $error("more than one name cell matched");

    // A result only ever follows a cycle in which an item was being worked on.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result shown without an item in progress");

    // A replaced edge can only be reported at the end of the edge write sequence.
    a_replaced_path: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_REPLACED) |-> $past(state_reg == S_WRITE2))
        else $error("edge replaced reported outside the edge write sequence");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the weighted graph adjacency store.
`default_nettype none

module testbench;

    import wgas_pkg::*;

    // The run is stopped as a failure if it has not finished by this cycle. The slowest
    // correct run is about 620 items plus long sender gaps, and the sweep of the weight
    // matrix after reset. That is well within this limit.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_PER_RUN = 200;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic         busy;
    wgas_item_t   item;
    logic         done;
    wgas_result_t result;

    weighted_graph_adjacency_store DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Our own copy of the graph. The name table only holds meaningful entries below
    // nodes_held, which is why nothing ever looks at a slot above that.
    logic [NAME_W-1:0]   slot_name [MAX_NODES_DEF];
    int                  nodes_held;
    logic [WEIGHT_W-1:0] weight_at [MAX_NODES_DEF*MAX_NODES_DEF];

    wgas_result_t pending_results [$];
    wgas_result_t oldest_pending;
    int           mismatch_count;
    int           cycle_count;
    int           sender_gap_pct;

    // Watchdog: a hung handshake must not leave the run going for ever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Records one failure. Only the first few are described in full, so that a badly
    // broken design does not bury the log.
    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Returns the slot that holds a name, or minus one if the name is not in the table.
    // The search runs from slot zero, so the first match wins.
    function automatic int slot_of(input logic [NAME_W-1:0] name);
        for (int i = 0; i < nodes_held; i++)
            if (slot_name[i] == name)
                return i;
        return -1;
    endfunction

    // Works out the result of one accepted item and brings our copy of the graph up to
    // date, exactly as the block should.
    function automatic wgas_result_t graph_predict(input wgas_item_t it);
        wgas_result_t        r;
        int                  o_slot;
        int                  d_slot;
        logic [WEIGHT_W-1:0] prior;
        r = '0;
        if (it.func == FUNC_NODE)
        begin
            // A full table is reported before a duplicate name is even looked for.
            if (nodes_held >= MAX_NODES_DEF)
                r.status = STATUS_FULL;
            else if (slot_of(it.first_name) >= 0)
                r.status = STATUS_DUP;
            else
            begin
                slot_name[nodes_held] = it.first_name;
                nodes_held++;
                r.status = STATUS_OK;
            end
        end
        else
        begin
            o_slot = slot_of(it.first_name);
            d_slot = slot_of(it.second_name);
            if (nodes_held == 0)
                r.status = STATUS_EMPTY;
            else if (o_slot < 0 || d_slot < 0)
                r.status = STATUS_UNKNOWN;
            else
            begin
                // The replaced flag looks at the entry before it is overwritten. A self
                // loop writes the one diagonal entry twice with the same weight, and a
                // weight of minus one quietly removes the edge.
                prior = weight_at[o_slot*MAX_NODES_DEF + d_slot];
                r.status = (prior != NO_EDGE) ? STATUS_REPLACED : STATUS_OK;
                weight_at[o_slot*MAX_NODES_DEF + d_slot] = it.edge_weight;
                weight_at[d_slot*MAX_NODES_DEF + o_slot] = it.edge_weight;
                r.origin_index = o_slot[IDX_OUT_W-1:0];
                r.dest_index   = d_slot[IDX_OUT_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic wgas_item_t make_item(input logic f, input logic [NAME_W-1:0] a,
                                             input logic [NAME_W-1:0] b,
                                             input logic [WEIGHT_W-1:0] w);
        wgas_item_t it;
        it.func        = f;
        it.first_name  = a;
        it.second_name = b;
        it.edge_weight = w;
        return it;
    endfunction

    // Offers one item and returns at the edge that accepts it. start is left high, so a
    // following item can go out back to back; it is only lowered for a gap or a drain.
    task automatic send_item(input wgas_item_t it);
        if ($urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_gap_pct);
        end
        start <= 1'b1;
        item  <= it;
        // busy is sampled as it stood just before the edge, so this loop leaves at the
        // very edge where the block takes the item.
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(graph_predict(it));
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Each result is on the ports for one cycle only, so it is taken on the edge that
    // ends that cycle and compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                note_mismatch($sformatf("result %p arrived with none expected", result));
            else
            begin
                oldest_pending = pending_results.pop_front();
                if (result.status !== oldest_pending.status ||
                    result.origin_index !== oldest_pending.origin_index ||
                    result.dest_index !== oldest_pending.dest_index)
                    note_mismatch($sformatf(
                        "status %0d origin %0d dest %0d, expected %0d %0d %0d",
                        result.status, result.origin_index, result.dest_index,
                        oldest_pending.status, oldest_pending.origin_index,
                        oldest_pending.dest_index));
            end
        end
    end

    // Edge inserts into an empty graph must be refused whatever the names and weight.
    task automatic test_empty_graph();
        send_item(make_item(FUNC_EDGE, 8'h00, 8'h00, 16'h7FFF));
        send_item(make_item(FUNC_EDGE, 8'hFF, 8'h12, 16'h8000));
    endtask

    // Appending nodes, with the extreme names, and duplicates refused.
    task automatic test_node_insert();
        send_item(make_item(FUNC_NODE, 8'h00, 8'hFF, 16'h8000));
        send_item(make_item(FUNC_NODE, 8'hFF, 8'h00, 16'h7FFF));
        send_item(make_item(FUNC_NODE, 8'hA5, 8'hFF, NO_EDGE));
        send_item(make_item(FUNC_NODE, 8'hFF, 8'h5A, 16'h0000));
        send_item(make_item(FUNC_NODE, 8'h00, 8'h00, 16'h1234));
    endtask

    // New, replaced, symmetric, self-loop and removed edges, and unknown end points.
    task automatic test_edge_insert();
        send_item(make_item(FUNC_EDGE, 8'h00, 8'hFF, 16'h7FFF));
        // The reverse direction finds the entry that the first write mirrored.
        send_item(make_item(FUNC_EDGE, 8'hFF, 8'h00, 16'h8000));
        send_item(make_item(FUNC_EDGE, 8'hA5, 8'hA5, 16'h0000));
        send_item(make_item(FUNC_EDGE, 8'hA5, 8'hA5, 16'h0001));
        send_item(make_item(FUNC_EDGE, 8'h5A, 8'h00, 16'h0002));
        send_item(make_item(FUNC_EDGE, 8'h00, 8'h5A, 16'h0003));
        send_item(make_item(FUNC_EDGE, 8'h5A, 8'hC3, 16'h0004));
        // A weight of minus one removes the edge, so the next write counts as new.
        send_item(make_item(FUNC_EDGE, 8'h00, 8'hFF, NO_EDGE));
        send_item(make_item(FUNC_EDGE, 8'hFF, 8'h00, 16'h0005));
        send_item(make_item(FUNC_EDGE, 8'hA5, 8'h00, 16'hFFFE));
    endtask

    // Weights lean towards the values with a meaning of their own.
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return NO_EDGE;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'h0000;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [NAME_W-1:0] pick_known_name();
        if (nodes_held == 0)
            return NAME_W'($urandom);
        return slot_name[$urandom_range(nodes_held - 1)];
    endfunction

    // Mostly well-formed traffic: edges between names already in the table, so that the
    // matrix fills and many writes replace an edge. The table fills early on, after which
    // every node insert, fresh name or duplicate, must report full.
    task automatic test_random_traffic(input int count, input int gap_pct);
        logic [NAME_W-1:0] a;
        logic [NAME_W-1:0] b;
        sender_gap_pct = gap_pct;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 30)
            begin
                a = ($urandom_range(99) < 65) ? NAME_W'($urandom) : pick_known_name();
                send_item(make_item(FUNC_NODE, a, NAME_W'($urandom), pick_weight()));
            end
            else
            begin
                a = ($urandom_range(99) < 90) ? pick_known_name() : NAME_W'($urandom);
                b = ($urandom_range(99) < 90) ? pick_known_name() : NAME_W'($urandom);
                send_item(make_item(FUNC_EDGE, a, b, pick_weight()));
            end
        end
        wait_for_drain();
    endtask

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        nodes_held     = 0;
        sender_gap_pct = 24;
        foreach (weight_at[i])
            weight_at[i] = NO_EDGE;
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // The block is busy clearing its matrix after reset; the first item simply waits
        // for busy to fall.
        test_empty_graph();
        test_node_insert();
        test_edge_insert();
        wait_for_drain();

        // The sender gaps go from light to heavy to none at all.
        test_random_traffic(RANDOM_PER_RUN, 24);
        test_random_traffic(RANDOM_PER_RUN, 68);
        test_random_traffic(RANDOM_PER_RUN, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
